[rtl/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// shared codes and reset values of the touch gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  typedef enum logic [2:0] {
    KIND_DOWN  = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_UP    = 3'd2,
    KIND_TAP   = 3'd3,
    KIND_LONG  = 3'd4,
    KIND_SWIPE = 3'd5
  } kind_e;

  // event types and codes
  localparam logic [15:0] EvTypeKey    = 16'd1;
  localparam logic [15:0] EvTypeAbs    = 16'd3;
  localparam logic [15:0] CodeAbsX     = 16'd0;
  localparam logic [15:0] CodeAbsY     = 16'd1;
  localparam logic [15:0] CodeMtX      = 16'd53;
  localparam logic [15:0] CodeMtY      = 16'd54;
  localparam logic [15:0] CodeTrackId  = 16'd57;
  localparam logic [15:0] CodeBtnTouch = 16'd330;

  // register indexes
  localparam logic [1:0] CfgLiveEnable = 2'd0;
  localparam logic [1:0] CfgSwipeDist2 = 2'd1;
  localparam logic [1:0] CfgLongpress  = 2'd2;
  localparam logic [1:0] CfgMoveStep   = 2'd3;

  // register reset values
  localparam logic [31:0] SwipeDist2Rst = 32'd784;
  localparam logic [15:0] LongpressRst  = 16'd600;
  localparam logic [15:0] MoveStepRst   = 16'd2;

  // reciprocal of 1000, exact floor for operands below 2**20
  localparam logic [20:0] RecipMilli    = 21'd1073742;
  localparam int          RecipShift    = 30;

endpackage

`default_nettype wire

[rtl/touch_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// touch event tracker with live down/move/up stream or tap/long/swipe output
// ----------------------------------------------------------------------------
// Accepts one touch event per clock cycle and gives at most one result per
// event. An event lands in an input register; the tracker state and the result
// register are updated from it when the result register is empty or being read,
// and that register then presents the result. The single pass holds the
// two squaring multipliers for the swipe distance and the constant
// multipliers for the hold time. Backpressure on the result side stalls the
// input only when the result register is still full.
`default_nettype none

module touch_gesture_classifier #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // event input
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // event_value[31:0], time_sec[63:32], time_usec[83:64], zero pad
  input  wire logic [87:0] s_axis_tdata,
  // event_type[15:0], event_code[31:16]
  input  wire logic [31:0] s_axis_tuser,
  // result output
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pos_x[15:0], pos_y[31:16], start_x[47:32], start_y[63:48], held_ms[95:64]
  output      logic [95:0] m_axis_tdata,
  // kind[2:0]
  output      logic [2:0]  m_axis_tuser
);

  import tgc_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int L1W = (C + 2 > 16) ? C + 2 : 17;
  localparam int D2W = (2 * C - 1 > 32) ? 2 * C - 1 : 33;
  localparam logic signed [C-1:0] CoordMax = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] CoordMin = {1'b1, {(C-1){1'b0}}};

  // config registers
  logic        live_en_q;
  logic [31:0] swipe_dist2_q;
  logic [15:0] longpress_q;
  logic [15:0] move_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_en_q     <= 1'b0;
      swipe_dist2_q <= SwipeDist2Rst;
      longpress_q   <= LongpressRst;
      move_step_q   <= MoveStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLiveEnable: live_en_q     <= cfg_data_i[0];
        CfgSwipeDist2: swipe_dist2_q <= cfg_data_i;
        CfgLongpress:  longpress_q   <= cfg_data_i[15:0];
        CfgMoveStep:   move_step_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_q;
  logic [15:0]        ev_type_q;
  logic [15:0]        ev_code_q;
  logic signed [31:0] ev_value_q;
  logic [31:0]        ev_sec_q;
  logic [19:0]        ev_usec_q;
  logic               adv;

  assign s_axis_tready = !in_valid_q || adv;
  assign adv           = in_valid_q && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev_type_q  <= s_axis_tuser[15:0];
      ev_code_q  <= s_axis_tuser[31:16];
      ev_value_q <= s_axis_tdata[31:0];
      ev_sec_q   <= s_axis_tdata[63:32];
      ev_usec_q  <= s_axis_tdata[83:64];
    end
  end

  // tracker state
  logic signed [C-1:0] cur_x_q, cur_y_q, begin_x_q, begin_y_q, sent_x_q, sent_y_q;
  logic signed [C-1:0] cur_x_d, cur_y_d, begin_x_d, begin_y_d, sent_x_d, sent_y_d;
  logic                in_contact_q, start_wait_q, live_gest_q;
  logic                in_contact_d, start_wait_d, live_gest_d;
  logic [31:0]         down_sec_q, down_sec_d;
  logic [19:0]         down_usec_q, down_usec_d;

  // event decode
  logic is_abs, is_axis, is_x, is_track, is_key, begin_req, rel_req, begin_ev, rel_ev;
  logic signed [32:0]  val_w;
  logic signed [C-1:0] val_sat;

  assign is_abs    = (ev_type_q == EvTypeAbs);
  assign is_x      = (ev_code_q == CodeAbsX) || (ev_code_q == CodeMtX);
  assign is_axis   = is_abs && (is_x || (ev_code_q == CodeAbsY) || (ev_code_q == CodeMtY));
  assign is_track  = is_abs && (ev_code_q == CodeTrackId);
  assign is_key    = (ev_type_q == EvTypeKey) && (ev_code_q == CodeBtnTouch);
  assign begin_req = (is_track && !ev_value_q[31]) || (is_key && (ev_value_q != 32'sd0));
  assign rel_req   = (is_track && ev_value_q[31]) || (is_key && (ev_value_q == 32'sd0));
  assign begin_ev  = begin_req && !in_contact_q;
  assign rel_ev    = rel_req && in_contact_q;

  assign val_w   = 33'(ev_value_q);
  assign val_sat = (val_w > 33'(CoordMax)) ? CoordMax :
                   (val_w < 33'(CoordMin)) ? CoordMin : C'(val_w);

  logic signed [C-1:0] cur_nx, cur_ny;
  assign cur_nx = (is_axis && is_x)  ? val_sat : cur_x_q;
  assign cur_ny = (is_axis && !is_x) ? val_sat : cur_y_q;

  logic capture;
  assign capture = ((is_axis && start_wait_q) || begin_ev) && !cur_nx[C-1] && !cur_ny[C-1];

  // L1 step from last sent point
  logic signed [C:0] stx, sty;
  logic [C:0]        stx_abs, sty_abs;
  logic [L1W-1:0]    l1;
  assign stx     = (C+1)'(cur_nx) - (C+1)'(sent_x_q);
  assign sty     = (C+1)'(cur_ny) - (C+1)'(sent_y_q);
  assign stx_abs = stx[C] ? (C+1)'(-stx) : (C+1)'(stx);
  assign sty_abs = sty[C] ? (C+1)'(-sty) : (C+1)'(sty);
  assign l1      = L1W'(stx_abs) + L1W'(sty_abs);

  // squared travel, valid when start and end are non-negative
  logic signed [C-1:0] dx, dy;
  logic [C-2:0]        dx_mag, dy_mag;
  logic [2*C-3:0]      sq_x, sq_y;
  logic [D2W-1:0]      dist2;
  assign dx     = cur_x_q - begin_x_q;
  assign dy     = cur_y_q - begin_y_q;
  assign dx_mag = dx[C-1] ? (C-1)'(-dx) : (C-1)'(dx);
  assign dy_mag = dy[C-1] ? (C-1)'(-dy) : (C-1)'(dy);
  assign sq_x   = dx_mag * dx_mag;
  assign sq_y   = dy_mag * dy_mag;
  assign dist2  = D2W'(sq_x) + D2W'(sq_y);

  // hold time in ms
  logic signed [32:0] sec_diff;
  logic signed [20:0] usec_diff;
  logic [19:0]        usec_mag;
  logic [40:0]        usec_prod;
  logic [10:0]        usec_q;
  logic signed [43:0] sec_ms, usec_ms, ms_sum;
  logic signed [31:0] held_ms;
  assign sec_diff  = $signed({1'b0, ev_sec_q}) - $signed({1'b0, down_sec_q});
  assign usec_diff = $signed({1'b0, ev_usec_q}) - $signed({1'b0, down_usec_q});
  assign usec_mag  = usec_diff[20] ? 20'(-usec_diff) : 20'(usec_diff);
  assign usec_prod = usec_mag * RecipMilli;
  assign usec_q    = usec_prod[RecipShift +: 11];
  assign sec_ms    = 44'(sec_diff) * 44'sd1000;
  assign usec_ms   = usec_diff[20] ? -$signed(44'(usec_q)) : $signed(44'(usec_q));
  assign ms_sum    = sec_ms + usec_ms;
  assign held_ms   = (ms_sum > 44'sd2147483647)  ? 32'sh7fffffff :
                     (ms_sum < -44'sd2147483648) ? 32'sh80000000 : 32'(ms_sum);

  logic class_ok;
  assign class_ok = !begin_x_q[C-1] && !begin_y_q[C-1] && !cur_x_q[C-1] && !cur_y_q[C-1];

  // result candidate
  logic                has_res;
  kind_e               res_kind;
  logic signed [C-1:0] res_px, res_py, res_sx, res_sy;
  logic signed [31:0]  res_held;

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    begin_x_d    = begin_x_q;
    begin_y_d    = begin_y_q;
    sent_x_d     = sent_x_q;
    sent_y_d     = sent_y_q;
    in_contact_d = in_contact_q;
    start_wait_d = start_wait_q;
    live_gest_d  = live_gest_q;
    down_sec_d   = down_sec_q;
    down_usec_d  = down_usec_q;
    has_res      = 1'b0;
    res_kind     = KIND_DOWN;
    res_px       = cur_nx;
    res_py       = cur_ny;
    res_sx       = begin_x_q;
    res_sy       = begin_y_q;
    res_held     = 32'sd0;
    if (adv) begin
      cur_x_d = cur_nx;
      cur_y_d = cur_ny;
      if (begin_ev) begin
        in_contact_d = 1'b1;
        start_wait_d = 1'b1;
        begin_x_d    = '1;
        begin_y_d    = '1;
      end
      if (capture) begin
        begin_x_d    = cur_nx;
        begin_y_d    = cur_ny;
        down_sec_d   = ev_sec_q;
        down_usec_d  = ev_usec_q;
        start_wait_d = 1'b0;
        if (live_en_q) begin
          live_gest_d = 1'b1;
          sent_x_d    = cur_nx;
          sent_y_d    = cur_ny;
          has_res     = 1'b1;
          res_kind    = KIND_DOWN;
          res_sx      = cur_nx;
          res_sy      = cur_ny;
        end
      end else if (is_axis && live_gest_q && (l1 >= L1W'(move_step_q))) begin
        sent_x_d = cur_nx;
        sent_y_d = cur_ny;
        has_res  = 1'b1;
        res_kind = KIND_MOVE;
      end
      if (rel_ev) begin
        in_contact_d = 1'b0;
        live_gest_d  = 1'b0;
        start_wait_d = 1'b0;
        begin_x_d    = '1;
        begin_y_d    = '1;
        res_held     = held_ms;
        if (live_gest_q) begin
          has_res  = 1'b1;
          res_kind = KIND_UP;
        end else if (class_ok) begin
          has_res = 1'b1;
          if (dist2 >= D2W'(swipe_dist2_q)) begin
            res_kind = KIND_SWIPE;
          end else if (held_ms >= $signed({16'b0, longpress_q})) begin
            res_kind = KIND_LONG;
          end else begin
            res_kind = KIND_TAP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '1;
      cur_y_q      <= '1;
      begin_x_q    <= '1;
      begin_y_q    <= '1;
      sent_x_q     <= '1;
      sent_y_q     <= '1;
      in_contact_q <= 1'b0;
      start_wait_q <= 1'b0;
      live_gest_q  <= 1'b0;
      down_sec_q   <= '0;
      down_usec_q  <= '0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      begin_x_q    <= begin_x_d;
      begin_y_q    <= begin_y_d;
      sent_x_q     <= sent_x_d;
      sent_y_q     <= sent_y_d;
      in_contact_q <= in_contact_d;
      start_wait_q <= start_wait_d;
      live_gest_q  <= live_gest_d;
      down_sec_q   <= down_sec_d;
      down_usec_q  <= down_usec_d;
    end
  end

  // result register
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [15:0] out_px_q, out_py_q, out_sx_q, out_sy_q;
  logic [31:0] out_held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= has_res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      out_kind_q <= res_kind;
      out_px_q   <= 16'(32'(res_px));
      out_py_q   <= 16'(32'(res_py));
      out_sx_q   <= 16'(32'(res_sx));
      out_sy_q   <= 16'(32'(res_sy));
      out_held_q <= res_held;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {out_held_q, out_sy_q, out_sx_q, out_py_q, out_px_q};

endmodule

`default_nettype wire

[rtl/tgc_checker.sv]
// ----------------------------------------------------------------------------
// tgc_checker
// port-level checks on the result stream of the touch gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  // pos_x[15:0], pos_y[31:16], start_x[47:32], start_y[63:48], held_ms[95:64]
  input wire logic [95:0] m_axis_tdata,
  // kind[2:0]
  input wire logic [2:0]  m_axis_tuser
);

  import tgc_pkg::*;

  // stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_SWIPE)
    else $error("result kind out of range");

  // down and move carry no hold time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DOWN || m_axis_tuser == KIND_MOVE) |->
      m_axis_tdata[95:64] == 32'd0)
    else $error("hold time on down or move");

  // down reports the captured start point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DOWN |->
      m_axis_tdata[15:0] == m_axis_tdata[47:32] &&
      m_axis_tdata[31:16] == m_axis_tdata[63:48])
    else $error("down point differs from start point");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[bench/touch_gesture_classifier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb
// self-checking bench for the touch gesture classifier
// ----------------------------------------------------------------------------
// Drives touch events into the slave stream and keeps its own tracker of
// contact, position, gesture start and hold time, giving the result due for
// every accepted event. Results on the master stream are checked field by
// field in order. Directed cases cover taps, long presses, swipes, live
// down/move/up, saturation and ignored events; random gestures and noise then
// run under several register settings and three idling profiles.

module touch_gesture_classifier_tb;
  import tgc_pkg::*;

  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 200000;
  localparam int ChunkItems   = 75;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [31:0] held_ms;
  } gesture_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // event_value[31:0], time_sec[63:32], time_usec[83:64], zero pad
  logic [87:0] s_axis_tdata  = '0;
  // event_type[15:0], event_code[31:16]
  logic [31:0] s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pos_x[15:0], pos_y[31:16], start_x[47:32], start_y[63:48], held_ms[95:64]
  logic [95:0] m_axis_tdata;
  // kind[2:0]
  logic [2:0]  m_axis_tuser;

  touch_gesture_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gesture_t    pending_gestures [$];
  int          send_idle_pct = 29;
  int          recv_idle_pct = 67;
  int          mismatches    = 0;
  int          events_sent   = 0;
  int          results_seen  = 0;
  int          kind_seen [6];
  int unsigned cycle_count   = 0;

  // event clock
  logic [31:0] now_sec  = '0;
  logic [19:0] now_usec = '0;

  // register copy
  logic        live_en  = 1'b0;
  logic [31:0] swipe_d2 = SwipeDist2Rst;
  logic [15:0] long_ms  = LongpressRst;
  logic [15:0] step_min = MoveStepRst;

  // tracker state
  logic signed [15:0] trk_x  = -16'sd1;
  logic signed [15:0] trk_y  = -16'sd1;
  logic signed [15:0] org_x  = -16'sd1;
  logic signed [15:0] org_y  = -16'sd1;
  logic signed [15:0] emit_x = -16'sd1;
  logic signed [15:0] emit_y = -16'sd1;
  logic               touching   = 1'b0;
  logic               arm_start  = 1'b0;
  logic               streaming  = 1'b0;
  logic [31:0]        t0_sec     = '0;
  logic [19:0]        t0_usec    = '0;

  function automatic logic signed [15:0] clamp_coord(logic [31:0] v);
    int s;
    s = v;
    if (s > 32767) return 16'sh7FFF;
    if (s < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int abs_gap(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic int hold_ms(logic [31:0] sec, logic [19:0] usec);
    longint s1, s0, u1, u0, ms, top, bottom;
    s1 = sec;
    s0 = t0_sec;
    u1 = usec;
    u0 = t0_usec;
    top = 2147483647;
    bottom = -top - 1;
    ms = (s1 - s0) * 1000 + (u1 - u0) / 1000;
    if (ms > top) ms = top;
    if (ms < bottom) ms = bottom;
    return int'(ms);
  endfunction

  function automatic void queue_gesture(kind_e kind, logic signed [15:0] px,
                                        logic signed [15:0] py, int held);
    gesture_t g;
    g.kind    = kind;
    g.pos_x   = px;
    g.pos_y   = py;
    g.start_x = org_x;
    g.start_y = org_y;
    g.held_ms = held;
    pending_gestures.push_back(g);
  endfunction

  function automatic bit capture_origin(logic [31:0] sec, logic [19:0] usec);
    if (!arm_start || trk_x[15] || trk_y[15]) return 1'b0;
    org_x = trk_x;
    org_y = trk_y;
    t0_sec = sec;
    t0_usec = usec;
    arm_start = 1'b0;
    if (!live_en) return 1'b0;
    streaming = 1'b1;
    emit_x = org_x;
    emit_y = org_y;
    queue_gesture(KIND_DOWN, org_x, org_y, 0);
    return 1'b1;
  endfunction

  function automatic void step_move();
    int step_len, lim;
    if (!streaming) return;
    step_len = abs_gap(trk_x, emit_x) + abs_gap(trk_y, emit_y);
    lim = step_min;
    if (step_len < lim) return;
    emit_x = trk_x;
    emit_y = trk_y;
    queue_gesture(KIND_MOVE, trk_x, trk_y, 0);
  endfunction

  function automatic void contact_open(logic [31:0] sec, logic [19:0] usec);
    if (touching) return;
    touching = 1'b1;
    arm_start = 1'b1;
    org_x = -16'sd1;
    org_y = -16'sd1;
    void'(capture_origin(sec, usec));
  endfunction

  function automatic void contact_close(logic [31:0] sec, logic [19:0] usec);
    int held, dx, dy, lp;
    longint ddx, ddy, d2, lim;
    held = hold_ms(sec, usec);
    touching = 1'b0;
    if (streaming) begin
      queue_gesture(KIND_UP, trk_x, trk_y, held);
    end else if (!org_x[15] && !org_y[15] && !trk_x[15] && !trk_y[15]) begin
      dx = trk_x - org_x;
      dy = trk_y - org_y;
      ddx = dx;
      ddy = dy;
      d2 = ddx * ddx + ddy * ddy;
      lim = swipe_d2;
      lp = long_ms;
      if (d2 >= lim) queue_gesture(KIND_SWIPE, trk_x, trk_y, held);
      else if (held >= lp) queue_gesture(KIND_LONG, trk_x, trk_y, held);
      else queue_gesture(KIND_TAP, trk_x, trk_y, held);
    end
    streaming = 1'b0;
    org_x = -16'sd1;
    org_y = -16'sd1;
    arm_start = 1'b0;
  endfunction

  function automatic void track_event(logic [15:0] typ, logic [15:0] code,
                                      logic [31:0] val, logic [31:0] sec,
                                      logic [19:0] usec);
    if (typ == EvTypeAbs) begin
      if (code == CodeAbsX || code == CodeMtX || code == CodeAbsY || code == CodeMtY) begin
        if (code == CodeAbsX || code == CodeMtX) trk_x = clamp_coord(val);
        else trk_y = clamp_coord(val);
        if (!capture_origin(sec, usec)) step_move();
      end else if (code == CodeTrackId) begin
        if (!val[31]) contact_open(sec, usec);
        else if (touching) contact_close(sec, usec);
      end
    end else if (typ == EvTypeKey && code == CodeBtnTouch) begin
      if (val != 0) contact_open(sec, usec);
      else if (touching) contact_close(sec, usec);
    end
  endfunction

  function automatic void set_time(logic [31:0] sec, logic [19:0] usec);
    now_sec = sec;
    now_usec = usec;
  endfunction

  function automatic void advance_time(int ms);
    longint u;
    u = now_usec;
    u = u + longint'(ms) * 1000 + $urandom_range(0, 999);
    now_sec = now_sec + 32'(u / 1000000);
    now_usec = 20'(u % 1000000);
  endfunction

  task automatic send_event(logic [15:0] typ, logic [15:0] code, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, now_usec, now_sec, val};
    s_axis_tuser  <= {code, typ};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
    track_event(typ, code, val, now_sec, now_usec);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_gestures.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgLiveEnable: live_en  = data[0];
      CfgSwipeDist2: swipe_d2 = data;
      CfgLongpress:  long_ms  = data[15:0];
      CfgMoveStep:   step_min = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_config(bit live, logic [31:0] dist2, logic [15:0] lp,
                              logic [15:0] step);
    cfg_write(CfgLiveEnable, {31'd0, live});
    cfg_write(CfgSwipeDist2, dist2);
    cfg_write(CfgLongpress, {16'd0, lp});
    cfg_write(CfgMoveStep, {16'd0, step});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_classified_release();
    set_time(0, 0);
    send_event(EvTypeAbs, CodeAbsX, 100);
    send_event(EvTypeAbs, CodeAbsY, 200);
    send_event(EvTypeKey, CodeBtnTouch, 1);
    advance_time(50);
    send_event(EvTypeAbs, CodeMtX, 110);
    advance_time(50);
    send_event(EvTypeKey, CodeBtnTouch, 0);
    // lift while already lifted, then a repeated begin
    send_event(EvTypeKey, CodeBtnTouch, 0);
    send_event(EvTypeAbs, CodeTrackId, 5);
    send_event(EvTypeAbs, CodeTrackId, 7);
    advance_time(700);
    send_event(EvTypeAbs, CodeTrackId, 32'hFFFF_FFFF);
    send_event(EvTypeAbs, CodeTrackId, 0);
    send_event(EvTypeAbs, CodeMtX, 200);
    send_event(EvTypeAbs, CodeMtY, 230);
    send_event(EvTypeAbs, CodeTrackId, 32'h8000_0000);
    // release with no start captured
    send_event(EvTypeAbs, CodeAbsX, -5);
    send_event(EvTypeKey, CodeBtnTouch, 32'h8000_0000);
    send_event(EvTypeKey, CodeBtnTouch, 0);
    send_event(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_event(EvTypeAbs, 16'hFFFF, 1);
  endtask

  task automatic test_live_stream();
    drain_results();
    write_config(1'b1, SwipeDist2Rst, LongpressRst, MoveStepRst);
    set_time(5, 999999);
    send_event(EvTypeAbs, CodeAbsX, 32'h7FFF_FFFF);
    send_event(EvTypeAbs, CodeAbsY, 32'h8000_0000);
    send_event(EvTypeKey, CodeBtnTouch, 1);
    send_event(EvTypeAbs, CodeAbsY, 32'h7FFF_FFFF);
    send_event(EvTypeAbs, CodeAbsX, 32'h8000_0000);
    send_event(EvTypeAbs, CodeAbsX, -32767);
    set_time(32'hFFFF_FFFF, 0);
    send_event(EvTypeKey, CodeBtnTouch, 0);
    // gesture started live and ended after switching to classified
    set_time(32'hFFFF_FFF0, 0);
    send_event(EvTypeAbs, CodeMtX, 10);
    send_event(EvTypeAbs, CodeMtY, 10);
    send_event(EvTypeKey, CodeBtnTouch, 1);
    drain_results();
    write_config(1'b0, SwipeDist2Rst, LongpressRst, MoveStepRst);
    set_time(0, 0);
    send_event(EvTypeKey, CodeBtnTouch, 0);
    // and the other way round
    send_event(EvTypeKey, CodeBtnTouch, 1);
    drain_results();
    write_config(1'b1, SwipeDist2Rst, LongpressRst, MoveStepRst);
    advance_time(30);
    send_event(EvTypeKey, CodeBtnTouch, 0);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(19))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32768, 100000);
      3: return -$urandom_range(1, 100000);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  task automatic random_gesture();
    int x, y, reach, steps;
    bit by_key;
    by_key = $urandom_range(1);
    x = rand_coord();
    y = rand_coord();
    case ($urandom_range(3))
      0: reach = 1;
      1: reach = 4;
      2: reach = 12;
      default: reach = 40;
    endcase
    if ($urandom_range(3) != 0) begin
      advance_time($urandom_range(1, 20));
      send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsX : CodeMtX, x);
      send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsY : CodeMtY, y);
    end
    advance_time($urandom_range(1, 20));
    if (by_key)
      send_event(EvTypeKey, CodeBtnTouch, ($urandom_range(3) == 0) ? ($urandom | 32'd1) : 32'd1);
    else
      send_event(EvTypeAbs, CodeTrackId,
                 ($urandom_range(3) == 0) ? ($urandom >> 1) : $urandom_range(0, 200));
    if ($urandom_range(4) != 0) begin
      send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsX : CodeMtX, x);
      send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsY : CodeMtY, y);
    end
    steps = $urandom_range(0, 6);
    repeat (steps) begin
      advance_time($urandom_range(5, 40));
      if ($urandom_range(1)) begin
        x = x + int'($urandom_range(0, 2 * reach)) - reach;
        send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsX : CodeMtX, x);
      end else begin
        y = y + int'($urandom_range(0, 2 * reach)) - reach;
        send_event(EvTypeAbs, $urandom_range(1) ? CodeAbsY : CodeMtY, y);
      end
    end
    advance_time(($urandom_range(3) == 0) ? $urandom_range(400, 1500) : $urandom_range(0, 300));
    if ($urandom_range(39) == 0) now_sec = $urandom;
    if ($urandom_range(9) == 0) by_key = !by_key;
    if (by_key) send_event(EvTypeKey, CodeBtnTouch, 0);
    else send_event(EvTypeAbs, CodeTrackId, $urandom | 32'h8000_0000);
  endtask

  task automatic random_noise();
    advance_time($urandom_range(0, 30));
    case ($urandom_range(3))
      0: send_event($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
      1: send_event(EvTypeAbs, $urandom_range(0, 60), $urandom);
      2: send_event(EvTypeKey, $urandom_range(1) ? CodeBtnTouch : $urandom_range(0, 65535),
                    $urandom_range(1) ? 32'd0 : $urandom);
      default: send_event(EvTypeAbs, CodeTrackId, $urandom);
    endcase
  endtask

  task automatic test_random_traffic(int phase);
    int chunk, mark;
    for (chunk = 0; chunk < 3; chunk++) begin
      drain_results();
      case (chunk)
        0: write_config(phase[0], 32'd0, 16'd0, 16'd0);
        1: write_config(!phase[0], 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        default: write_config($urandom_range(1), $urandom_range(0, 3000),
                              $urandom_range(0, 1200), $urandom_range(0, 40));
      endcase
      mark = events_sent;
      while (events_sent - mark < ChunkItems) begin
        if ($urandom_range(99) < 80) random_gesture();
        else random_noise();
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    gesture_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
               m_axis_tdata[63:48], m_axis_tdata[95:64]};
        results_seen++;
        if (got.kind <= KIND_SWIPE) kind_seen[got.kind]++;
        if (pending_gestures.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result: kind %0d pos (%0d,%0d) held %0d", got.kind,
                     $signed(got.pos_x), $signed(got.pos_y), $signed(got.held_ms));
        end else begin
          want = pending_gestures.pop_front();
          if (got.kind != want.kind || got.pos_x != want.pos_x || got.pos_y != want.pos_y ||
              got.start_x != want.start_x || got.start_y != want.start_y ||
              got.held_ms != want.held_ms) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("result %0d mismatch: exp kind %0d pos (%0d,%0d) start (%0d,%0d) held %0d",
                       results_seen, want.kind, $signed(want.pos_x), $signed(want.pos_y),
                       $signed(want.start_x), $signed(want.start_y), $signed(want.held_ms));
              $display("  got kind %0d pos (%0d,%0d) start (%0d,%0d) held %0d", got.kind,
                       $signed(got.pos_x), $signed(got.pos_y), $signed(got.start_x),
                       $signed(got.start_y), $signed(got.held_ms));
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("touch_gesture_classifier_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_classified_release();
    test_live_stream();
    test_random_traffic(0);
    send_idle_pct = 67;
    recv_idle_pct = 29;
    test_random_traffic(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(2);
    drain_results();
    mismatches += pending_gestures.size();
    $display("%0d events, %0d results: down %0d move %0d up %0d tap %0d long %0d swipe %0d",
             events_sent, results_seen, kind_seen[0], kind_seen[1], kind_seen[2],
             kind_seen[3], kind_seen[4], kind_seen[5]);
    $display("live and classified modes, register extremes, three idling profiles, %0d %s",
             mismatches, "mismatches");
    if (mismatches == 0) begin
      $display("touch_gesture_classifier_tb: PASS");
    end else begin
      $display("touch_gesture_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tgc_pkg.sv
rtl/touch_gesture_classifier.sv
rtl/tgc_checker.sv
bench/touch_gesture_classifier_tb.sv
